### rtl/core/pngu_pkg.sv
// ----------------------------------------------------------------------------
// pngu_pkg
// Shared constants, types and helper functions of the PNG scanline unfilter.
// ----------------------------------------------------------------------------
package pngu_pkg;

    localparam int MAX_WIDTH       = 1024;
    localparam int PALETTE_ENTRIES = 256;
    localparam int MAX_HEIGHT      = 1024;

    localparam int ROW_LIMIT = MAX_WIDTH * 4;
    localparam int ROW_AW    = $clog2(ROW_LIMIT);
    localparam int COL_W     = $clog2(ROW_LIMIT + 1);
    localparam int WCMP_W    = (COL_W > 11) ? COL_W : 11;
    localparam int ROWC_W    = $clog2(MAX_HEIGHT);
    localparam int PAL_AW    = (PALETTE_ENTRIES > 2) ? $clog2(PALETTE_ENTRIES) : 1;

    // floor(k / 3) = (k * DIV3_MUL) >> DIV3_SH, exact for k < 2**16
    localparam int DIV3_MUL = 43691;
    localparam int DIV3_SH  = 17;

    localparam logic [1:0] KIND_IMAGE   = 2'd0;
    localparam logic [1:0] KIND_PALETTE = 2'd1;
    localparam logic [1:0] KIND_ALPHA   = 2'd2;

    localparam logic [2:0] FILT_NONE  = 3'd0;
    localparam logic [2:0] FILT_SUB   = 3'd1;
    localparam logic [2:0] FILT_UP    = 3'd2;
    localparam logic [2:0] FILT_AVG   = 3'd3;
    localparam logic [2:0] FILT_PAETH = 3'd4;

    localparam logic [2:0] FMT_GRAY    = 3'd0;
    localparam logic [2:0] FMT_RGB     = 3'd1;
    localparam logic [2:0] FMT_PALETTE = 3'd2;
    localparam logic [2:0] FMT_GRAYA   = 3'd3;
    localparam logic [2:0] FMT_RGBA    = 3'd4;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_FORMAT = 2'd2;
    localparam logic [1:0] REG_TRNS   = 2'd3;

    typedef struct packed {
        logic [10:0] width;
        logic [10:0] height;
        logic [2:0]  format;
        logic        trns_en;
    } t_cfg;

    typedef enum logic [1:0] {
        S1_PIXEL    = 2'd0,
        S1_PAL_WR   = 2'd1,
        S1_ALPHA_WR = 2'd2
    } t_s1_kind;

    typedef struct packed {
        t_s1_kind    kind;
        logic [7:0]  idx;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [9:0]  col;
        logic        row_end;
        logic        image_end;
        logic        use_pal;
        logic        use_trns;
    } t_s1;

    function automatic logic [2:0] bytes_per_pixel(input logic [2:0] fmt);
        logic [2:0] n;
        unique case (fmt)
            FMT_GRAY:    n = 3'd1;
            FMT_RGB:     n = 3'd3;
            FMT_PALETTE: n = 3'd1;
            FMT_GRAYA:   n = 3'd2;
            default:     n = 3'd4;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] byte_at(input logic [31:0] w, input logic [2:0] lag);
        logic [7:0] b;
        case (lag)
            3'd1:    b = w[7:0];
            3'd2:    b = w[15:8];
            3'd3:    b = w[23:16];
            default: b = w[31:24];
        endcase
        return b;
    endfunction

    function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] c);
        logic signed [10:0] p;
        logic signed [10:0] pa;
        logic signed [10:0] pb;
        logic signed [10:0] pc;
        logic [7:0]         r;
        p  = $signed({3'b000, a}) + $signed({3'b000, b}) - $signed({3'b000, c});
        pa = p - $signed({3'b000, a});
        pb = p - $signed({3'b000, b});
        pc = p - $signed({3'b000, c});
        if (pa < 0) pa = -pa;
        if (pb < 0) pb = -pb;
        if (pc < 0) pc = -pc;
        if (pa <= pb && pa <= pc) begin
            r = a;
        end else if (pb <= pc) begin
            r = b;
        end else begin
            r = c;
        end
        return r;
    endfunction

endpackage

### rtl/core/pngu_if.sv
// ----------------------------------------------------------------------------
// pngu_if
// Request channels of the PNG scanline unfilter: input, output, config.
// ----------------------------------------------------------------------------
interface pngu_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] image_byte;
    logic [7:0] table_index;
    logic [7:0] table_red;
    logic [7:0] table_green;
    logic [7:0] table_blue;
    logic [7:0] table_alpha;

    modport source (output valid, kind, image_byte, table_index, table_red, table_green,
                    table_blue, table_alpha, input ready);
    modport sink (input valid, kind, image_byte, table_index, table_red, table_green,
                  table_blue, table_alpha, output ready);
endinterface

interface pngu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [9:0] pixel_column;
    logic       row_end;
    logic       image_end;

    modport source (output valid, red, green, blue, alpha, pixel_column, row_end,
                    image_end, input ready);
    modport sink (input valid, red, green, blue, alpha, pixel_column, row_end,
                  image_end, output ready);
endinterface

interface pngu_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [10:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### rtl/core/pngu_ram.sv
// ----------------------------------------------------------------------------
// pngu_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pngu_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/pngu_unfilter.sv
// ----------------------------------------------------------------------------
// pngu_unfilter
// Row tracking and PNG filter reconstruction; builds a pixel request from each
// pixel's last byte, or a table write request, into the first stage register.
// ----------------------------------------------------------------------------
module pngu_unfilter (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  pngu_pkg::t_cfg i_cfg,
    pngu_in_if.sink       i_in,
    output logic          o_s1_valid,
    output pngu_pkg::t_s1 o_s1,
    input  logic          i_s1_ready
);

    localparam int AW = pngu_pkg::ROW_AW;
    localparam int CW = pngu_pkg::COL_W;
    localparam int WW = pngu_pkg::WCMP_W;
    localparam int RW = pngu_pkg::ROWC_W;

    logic [CW-1:0]  r_byte_col, n_byte_col;
    logic [2:0]     r_filter, n_filter;
    logic [31:0]    r_recent, n_recent;
    logic [31:0]    r_upleft, n_upleft;
    logic [RW-1:0]  r_row_cnt, n_row_cnt;
    logic           r_s1_valid, n_s1_valid;
    pngu_pkg::t_s1  r_s1, n_s1;

    logic           in_rdy;
    logic           acc;
    logic [2:0]     bpp;
    logic [CW-1:0]  k_raw;
    logic [AW-1:0]  k;
    logic [CW-1:0]  nk_raw;
    logic           has_left;
    logic           row_nz;
    logic [7:0]     ram_q;
    logic [7:0]     left;
    logic [7:0]     above;
    logic [7:0]     upl;
    logic [8:0]     avg_sum;
    logic [7:0]     pred;
    logic [7:0]     recon;
    logic [AW+16:0] prod3;
    logic [AW-1:0]  q3;
    logic [AW-1:0]  r3;
    logic [AW-1:0]  col;
    logic [AW+9:0]  col_wide;
    logic [1:0]     chan;
    logic [WW-1:0]  w_eff;
    logic [WW+2:0]  row_bytes;
    logic [10:0]    h_eff;
    logic           hard_end;
    logic           pix_end;
    logic           row_end;
    logic           img_end;
    logic           tidx_ok;
    logic           ram_we;
    pngu_pkg::t_s1  px;

    assign in_rdy     = !r_s1_valid || i_s1_ready;
    assign acc        = i_in.valid && in_rdy;
    assign i_in.ready = in_rdy;

    assign bpp      = pngu_pkg::bytes_per_pixel(i_cfg.format);
    assign k_raw    = r_byte_col - CW'(1);
    assign k        = k_raw[AW-1:0];
    assign nk_raw   = n_byte_col - CW'(1);
    assign has_left = k >= AW'(bpp);
    assign row_nz   = r_row_cnt != '0;

    pngu_ram #(
        .DEPTH (pngu_pkg::ROW_LIMIT),
        .WIDTH (8)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (k),
        .i_wdata (recon),
        .i_re    (1'b1),
        .i_raddr (nk_raw[AW-1:0]),
        .o_rdata (ram_q)
    );

    assign left  = has_left ? pngu_pkg::byte_at(r_recent, bpp) : 8'd0;
    assign upl   = (has_left && row_nz) ? pngu_pkg::byte_at(r_upleft, bpp) : 8'd0;
    assign above = row_nz ? ram_q : 8'd0;

    assign avg_sum = {1'b0, left} + {1'b0, above};

    always_comb begin
        case (r_filter)
            pngu_pkg::FILT_SUB:   pred = left;
            pngu_pkg::FILT_UP:    pred = above;
            pngu_pkg::FILT_AVG:   pred = avg_sum[8:1];
            pngu_pkg::FILT_PAETH: pred = pngu_pkg::paeth(left, above, upl);
            default:              pred = 8'd0;
        endcase
    end

    assign recon = i_in.image_byte + pred;

    // pixel index and channel within the pixel
    assign prod3 = {17'd0, k} * (AW + 17)'(pngu_pkg::DIV3_MUL);
    assign q3    = prod3[AW+16:pngu_pkg::DIV3_SH];
    assign r3    = k - (q3 << 1) - q3;

    always_comb begin
        case (bpp)
            3'd1: begin
                col  = k;
                chan = 2'd0;
            end
            3'd2: begin
                col  = k >> 1;
                chan = {1'b0, k[0]};
            end
            3'd3: begin
                col  = q3;
                chan = r3[1:0];
            end
            default: begin
                col  = k >> 2;
                chan = k[1:0];
            end
        endcase
    end

    assign col_wide = {10'd0, col};

    always_comb begin
        if (i_cfg.width == '0) begin
            w_eff = WW'(1);
        end else if (WW'(i_cfg.width) > WW'(pngu_pkg::MAX_WIDTH)) begin
            w_eff = WW'(pngu_pkg::MAX_WIDTH);
        end else begin
            w_eff = WW'(i_cfg.width);
        end
        if (i_cfg.height == '0) begin
            h_eff = 11'd1;
        end else if (i_cfg.height > 11'(pngu_pkg::MAX_HEIGHT)) begin
            h_eff = 11'(pngu_pkg::MAX_HEIGHT);
        end else begin
            h_eff = i_cfg.height;
        end
    end

    assign row_bytes = (WW + 3)'(w_eff) * (WW + 3)'(bpp);
    assign hard_end  = r_byte_col >= CW'(pngu_pkg::ROW_LIMIT);
    assign pix_end   = ({1'b0, chan} == bpp - 3'd1) || hard_end;
    assign row_end   = ((WW + 3)'(r_byte_col) >= row_bytes) || hard_end;
    assign img_end   = row_end && ((11'(r_row_cnt) + 11'd1) >= h_eff);
    assign tidx_ok   = {1'b0, i_in.table_index} < 9'(pngu_pkg::PALETTE_ENTRIES);

    always_comb begin
        px           = '0;
        px.kind      = pngu_pkg::S1_PIXEL;
        px.idx       = recon;
        px.col       = col_wide[9:0];
        px.row_end   = row_end;
        px.image_end = img_end;
        px.use_pal   = 1'b0;
        px.use_trns  = i_cfg.trns_en;
        case (i_cfg.format)
            pngu_pkg::FMT_GRAY: begin
                px.red   = recon;
                px.green = recon;
                px.blue  = recon;
                px.alpha = 8'd255;
            end
            pngu_pkg::FMT_RGB: begin
                px.red   = r_recent[15:8];
                px.green = r_recent[7:0];
                px.blue  = recon;
                px.alpha = 8'd255;
            end
            pngu_pkg::FMT_PALETTE: begin
                px.use_pal = 1'b1;
            end
            pngu_pkg::FMT_GRAYA: begin
                px.red   = r_recent[7:0];
                px.green = r_recent[7:0];
                px.blue  = r_recent[7:0];
                px.alpha = recon;
            end
            default: begin
                px.red   = r_recent[23:16];
                px.green = r_recent[15:8];
                px.blue  = r_recent[7:0];
                px.alpha = recon;
            end
        endcase
    end

    always_comb begin
        n_byte_col = r_byte_col;
        n_filter   = r_filter;
        n_recent   = r_recent;
        n_upleft   = r_upleft;
        n_row_cnt  = r_row_cnt;
        n_s1_valid = r_s1_valid && !i_s1_ready;
        n_s1       = r_s1;
        ram_we     = 1'b0;
        if (acc) begin
            unique case (i_in.kind)
                pngu_pkg::KIND_IMAGE: begin
                    if (r_byte_col == '0) begin
                        n_filter   = (i_in.image_byte <= {5'd0, pngu_pkg::FILT_PAETH})
                                   ? i_in.image_byte[2:0] : pngu_pkg::FILT_NONE;
                        n_byte_col = CW'(1);
                        n_recent   = '0;
                        n_upleft   = '0;
                    end else begin
                        ram_we     = 1'b1;
                        n_recent   = {r_recent[23:0], recon};
                        n_upleft   = {r_upleft[23:0], above};
                        n_byte_col = r_byte_col + CW'(1);
                        if (pix_end) begin
                            n_s1_valid = 1'b1;
                            n_s1       = px;
                            if (row_end) begin
                                n_byte_col = '0;
                                n_row_cnt  = img_end ? '0 : r_row_cnt + RW'(1);
                            end
                        end
                    end
                end
                pngu_pkg::KIND_PALETTE, pngu_pkg::KIND_ALPHA: begin
                    if (tidx_ok) begin
                        n_s1_valid = 1'b1;
                        n_s1       = '0;
                        n_s1.kind  = (i_in.kind == pngu_pkg::KIND_PALETTE)
                                   ? pngu_pkg::S1_PAL_WR : pngu_pkg::S1_ALPHA_WR;
                        n_s1.idx   = i_in.table_index;
                        n_s1.red   = i_in.table_red;
                        n_s1.green = i_in.table_green;
                        n_s1.blue  = i_in.table_blue;
                        n_s1.alpha = i_in.table_alpha;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_col <= '0;
            r_filter   <= pngu_pkg::FILT_NONE;
            r_recent   <= '0;
            r_upleft   <= '0;
            r_row_cnt  <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_byte_col <= n_byte_col;
            r_filter   <= n_filter;
            r_recent   <= n_recent;
            r_upleft   <= n_upleft;
            r_row_cnt  <= n_row_cnt;
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1 <= n_s1;
    end

    assign o_s1_valid = r_s1_valid;
    assign o_s1       = r_s1;

endmodule

### rtl/core/pngu_palette.sv
// ----------------------------------------------------------------------------
// pngu_palette
// Palette and transparency tables, table writes in request order, and the
// output register of the pixel channel.
// ----------------------------------------------------------------------------
module pngu_palette (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s1_valid,
    input  pngu_pkg::t_s1 i_s1,
    output logic          o_s1_ready,
    pngu_out_if.source    o_out
);

    localparam int PN = pngu_pkg::PALETTE_ENTRIES;
    localparam int PA = pngu_pkg::PAL_AW;

    logic                r_out_valid, n_out_valid;
    pngu_pkg::t_s1       r_px;
    logic                r_in_range;
    logic                r_alpha_set_q;
    logic [PN-1:0]       r_alpha_set;

    logic                ready_s1;
    logic                load_px;
    logic                pal_we;
    logic                alpha_we;
    logic [23:0]         pal_q;
    logic [7:0]          alpha_q;
    logic [PA-1:0]       addr;

    assign ready_s1   = (i_s1.kind != pngu_pkg::S1_PIXEL) || !r_out_valid || o_out.ready;
    assign o_s1_ready = ready_s1;
    assign load_px    = i_s1_valid && (i_s1.kind == pngu_pkg::S1_PIXEL) && ready_s1;
    assign pal_we     = i_s1_valid && (i_s1.kind == pngu_pkg::S1_PAL_WR);
    assign alpha_we   = i_s1_valid && (i_s1.kind == pngu_pkg::S1_ALPHA_WR);
    assign addr       = i_s1.idx[PA-1:0];

    pngu_ram #(
        .DEPTH (PN),
        .WIDTH (24)
    ) u_pal_ram (
        .i_clk   (i_clk),
        .i_we    (pal_we),
        .i_waddr (addr),
        .i_wdata ({i_s1.red, i_s1.green, i_s1.blue}),
        .i_re    (load_px),
        .i_raddr (addr),
        .o_rdata (pal_q)
    );

    pngu_ram #(
        .DEPTH (PN),
        .WIDTH (8)
    ) u_alpha_ram (
        .i_clk   (i_clk),
        .i_we    (alpha_we),
        .i_waddr (addr),
        .i_wdata (i_s1.alpha),
        .i_re    (load_px),
        .i_raddr (addr),
        .o_rdata (alpha_q)
    );

    always_comb begin
        n_out_valid = r_out_valid && !o_out.ready;
        if (load_px) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_alpha_set <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            if (alpha_we) begin
                r_alpha_set[addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_px) begin
            r_px          <= i_s1;
            r_in_range    <= {1'b0, i_s1.idx} < 9'(PN);
            r_alpha_set_q <= r_alpha_set[addr];
        end
    end

    always_comb begin
        o_out.red   = r_px.red;
        o_out.green = r_px.green;
        o_out.blue  = r_px.blue;
        o_out.alpha = r_px.alpha;
        if (r_px.use_pal) begin
            if (r_in_range) begin
                o_out.red   = pal_q[23:16];
                o_out.green = pal_q[15:8];
                o_out.blue  = pal_q[7:0];
                // unwritten transparency entries read as opaque
                o_out.alpha = (r_px.use_trns && r_alpha_set_q) ? alpha_q : 8'd255;
            end else begin
                o_out.red   = 8'd0;
                o_out.green = 8'd0;
                o_out.blue  = 8'd0;
                o_out.alpha = 8'd255;
            end
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.pixel_column = r_px.col;
    assign o_out.row_end      = r_px.row_end;
    assign o_out.image_end    = r_px.image_end;

endmodule

### rtl/core/png_scanline_unfilter_top.sv
// ----------------------------------------------------------------------------
// png_scanline_unfilter_top
// PNG scanline unfilter (none/sub/up/average/Paeth) with RGBA conversion for
// gray, RGB, palette, gray-alpha and RGBA images, 8 bits per sample.
//
//   channel  dir  request content
//   i_in     in   image byte (filter byte at row start) or table write
//   o_out    out  RGBA pixel, column, row end, image end
//   i_cfg    in   register index and write data, always ready
//
// One item per cycle sustained while the output is not stalled. Once its last byte
// is accepted, a pixel passes the filter stage reg, then palette read / output reg.
// The row-above memory is read one byte ahead, so back-to-back bytes of a
// row see their above byte without a bubble.
// Reset is synchronous; the row-above and palette memories are not cleared.
// A stalled output holds its pixel while one more request waits in stage one.
// ----------------------------------------------------------------------------
module png_scanline_unfilter_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pngu_in_if.sink    i_in,
    pngu_out_if.source o_out,
    pngu_cfg_if.sink   i_cfg
);

    pngu_pkg::t_cfg r_cfg, n_cfg;
    logic           s1_valid;
    pngu_pkg::t_s1  s1;
    logic           s1_ready;

    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            unique case (i_cfg.index)
                pngu_pkg::REG_WIDTH:  n_cfg.width   = i_cfg.data;
                pngu_pkg::REG_HEIGHT: n_cfg.height  = i_cfg.data;
                pngu_pkg::REG_FORMAT: n_cfg.format  = i_cfg.data[2:0];
                pngu_pkg::REG_TRNS:   n_cfg.trns_en = i_cfg.data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width   <= 11'd1;
            r_cfg.height  <= 11'd1;
            r_cfg.format  <= pngu_pkg::FMT_RGB;
            r_cfg.trns_en <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    pngu_unfilter u_unfilter (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in       (i_in),
        .o_s1_valid (s1_valid),
        .o_s1       (s1),
        .i_s1_ready (s1_ready)
    );

    pngu_palette u_palette (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s1_valid (s1_valid),
        .i_s1       (s1),
        .o_s1_ready (s1_ready),
        .o_out      (o_out)
    );

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for png_scanline_unfilter_top. Streams whole images in
// every pixel format and row filter, mixed with palette and alpha table
// writes, under random stalls on both sides. Each RGBA pixel is predicted and
// compared field by field with the block's output.
// ----------------------------------------------------------------------------
module tb;

    localparam logic [1:0] KIND_IGNORED = 2'd3;
    localparam logic [2:0] FMT_ALT_LO   = 3'd5;
    localparam logic [2:0] FMT_ALT_HI   = 3'd7;
    localparam logic [7:0] FILT_BAD_LO  = 8'd5;
    localparam logic [7:0] FILT_BAD_HI  = 8'd255;
    localparam int DRAIN_CYCLES  = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_BYTES  = 60;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] image_byte;
        logic [7:0] table_index;
        logic [7:0] table_red;
        logic [7:0] table_green;
        logic [7:0] table_blue;
        logic [7:0] table_alpha;
    } t_pixel_req;

    localparam int REQ_W = $bits(t_pixel_req);

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [9:0] pixel_column;
        logic       row_end;
        logic       image_end;
    } t_rgba;

    class pixel_predictor;
        logic [7:0]  above_row [pngu_pkg::ROW_LIMIT];
        logic [31:0] recent;
        logic [31:0] upper_left;
        logic [2:0]  filter;
        int unsigned byte_col;
        int unsigned row_idx;
        logic [23:0] palette [pngu_pkg::PALETTE_ENTRIES];
        logic [7:0]  trns [pngu_pkg::PALETTE_ENTRIES];
        pngu_pkg::t_cfg cfg;
        t_rgba       expected_pixels [$];
        int          errors;

        function new();
            foreach (above_row[i]) above_row[i] = '0;
            foreach (palette[i]) palette[i] = '0;
            foreach (trns[i]) trns[i] = 8'd255;
            recent     = '0;
            upper_left = '0;
            filter     = pngu_pkg::FILT_NONE;
            byte_col   = 0;
            row_idx    = 0;
            cfg        = '{width: 11'd1, height: 11'd1, format: pngu_pkg::FMT_RGB,
                           trns_en: 1'b0};
            errors     = 0;
        endfunction

        function int unsigned pixel_bytes();
            case (cfg.format)
                pngu_pkg::FMT_GRAY, pngu_pkg::FMT_PALETTE: return 1;
                pngu_pkg::FMT_RGB:                         return 3;
                pngu_pkg::FMT_GRAYA:                       return 2;
                default:                                   return 4;
            endcase
        endfunction

        function int unsigned row_width();
            int unsigned w;
            w = (cfg.width == 0) ? 1 : cfg.width;
            return (w > pngu_pkg::MAX_WIDTH) ? pngu_pkg::MAX_WIDTH : w;
        endfunction

        function int unsigned row_total();
            int unsigned h;
            h = (cfg.height == 0) ? 1 : cfg.height;
            return (h > pngu_pkg::MAX_HEIGHT) ? pngu_pkg::MAX_HEIGHT : h;
        endfunction

        function void write_reg(logic [1:0] idx, logic [10:0] data);
            case (idx)
                pngu_pkg::REG_WIDTH:  cfg.width   = data;
                pngu_pkg::REG_HEIGHT: cfg.height  = data;
                pngu_pkg::REG_FORMAT: cfg.format  = data[2:0];
                default:              cfg.trns_en = data[0];
            endcase
        endfunction

        function logic [7:0] lane(logic [31:0] w, int unsigned d);
            return w[8*(d-1) +: 8];
        endfunction

        function int paeth_pick(int a, int b, int c);
            int p, da, db, dc;
            p  = a + b - c;
            da = (p > a) ? p - a : a - p;
            db = (p > b) ? p - b : b - p;
            dc = (p > c) ? p - c : c - p;
            if (da <= db && da <= dc) return a;
            if (db <= dc) return b;
            return c;
        endfunction

        function void take_request(t_pixel_req r);
            int unsigned n, k, left, above, ul, pred;
            logic [7:0]  recon;
            bit          px_end, rw_end, im_end;
            t_rgba       px;
            case (r.kind)
                pngu_pkg::KIND_PALETTE: begin
                    palette[r.table_index] = {r.table_red, r.table_green, r.table_blue};
                end
                pngu_pkg::KIND_ALPHA: trns[r.table_index] = r.table_alpha;
                default: ;
            endcase
            if (r.kind != pngu_pkg::KIND_IMAGE) return;
            if (byte_col == 0) begin
                filter     = (r.image_byte <= pngu_pkg::FILT_PAETH) ? r.image_byte[2:0]
                                                                    : pngu_pkg::FILT_NONE;
                byte_col   = 1;
                recent     = '0;
                upper_left = '0;
                return;
            end
            n = pixel_bytes();
            k = byte_col - 1;
            if (k >= pngu_pkg::ROW_LIMIT) k = pngu_pkg::ROW_LIMIT - 1;
            left  = (k >= n) ? lane(recent, n) : 0;
            ul    = (k >= n && row_idx != 0) ? lane(upper_left, n) : 0;
            above = (row_idx != 0) ? above_row[k] : 0;
            case (filter)
                pngu_pkg::FILT_SUB:   pred = left;
                pngu_pkg::FILT_UP:    pred = above;
                pngu_pkg::FILT_AVG:   pred = (left + above) >> 1;
                pngu_pkg::FILT_PAETH: pred = paeth_pick(left, above, ul);
                default:              pred = 0;
            endcase
            recon        = 8'(r.image_byte + pred);
            upper_left   = {upper_left[23:0], 8'(above)};
            recent       = {recent[23:0], recon};
            above_row[k] = recon;

            px_end = (k % n == n - 1) || (k + 1 >= pngu_pkg::ROW_LIMIT);
            if (!px_end) begin
                byte_col = k + 2;
                return;
            end
            rw_end = (k + 1 >= row_width() * n) || (k + 1 >= pngu_pkg::ROW_LIMIT);
            im_end = 1'b0;
            if (rw_end) begin
                byte_col = 0;
                if (row_idx + 1 >= row_total()) begin
                    im_end  = 1'b1;
                    row_idx = 0;
                end else begin
                    row_idx++;
                end
            end else begin
                byte_col = k + 2;
            end

            px.alpha = 8'd255;
            case (cfg.format)
                pngu_pkg::FMT_GRAY: {px.red, px.green, px.blue} = {3{recon}};
                pngu_pkg::FMT_RGB: begin
                    px.red   = lane(recent, 3);
                    px.green = lane(recent, 2);
                    px.blue  = recon;
                end
                pngu_pkg::FMT_PALETTE: begin
                    {px.red, px.green, px.blue} = palette[recon];
                    if (cfg.trns_en) px.alpha = trns[recon];
                end
                pngu_pkg::FMT_GRAYA: begin
                    {px.red, px.green, px.blue} = {3{lane(recent, 2)}};
                    px.alpha = recon;
                end
                default: begin
                    px.red   = lane(recent, 4);
                    px.green = lane(recent, 3);
                    px.blue  = lane(recent, 2);
                    px.alpha = recon;
                end
            endcase
            px.pixel_column = 10'(k / n);
            px.row_end      = rw_end;
            px.image_end    = im_end;
            expected_pixels.push_back(px);
        endfunction

        function void check_field(string name, int want, int got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_pixel(t_rgba got);
            t_rgba want;
            if (expected_pixels.size() == 0) begin
                $error("pixel with no expectation at column %0d", got.pixel_column);
                errors++;
                return;
            end
            want = expected_pixels.pop_front();
            check_field("red", want.red, got.red);
            check_field("green", want.green, got.green);
            check_field("blue", want.blue, got.blue);
            check_field("alpha", want.alpha, got.alpha);
            check_field("pixel_column", want.pixel_column, got.pixel_column);
            check_field("row_end", want.row_end, got.row_end);
            check_field("image_end", want.image_end, got.image_end);
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    pngu_in_if  in_if ();
    pngu_out_if out_if ();
    pngu_cfg_if cfg_if ();

    png_scanline_unfilter_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    pixel_predictor pred;
    int             idle_pct = 35;
    bit             hold_output = 1'b0;
    int unsigned    image_bytes_sent = 0;

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            pred.check_pixel(t_rgba'({out_if.red, out_if.green, out_if.blue, out_if.alpha,
                                      out_if.pixel_column, out_if.row_end,
                                      out_if.image_end}));
        end
    end

    // pixel receiver; a requested hold keeps ready low for a long stretch
    initial begin
        out_if.ready <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (hold_output) begin
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_output = 1'b0;
            end
            out_if.ready <= ($urandom_range(99) >= idle_pct);
            @(posedge i_clk);
        end
    end

    task automatic send_request(t_pixel_req r);
        while ($urandom_range(99) < idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.kind        <= r.kind;
        in_if.image_byte  <= r.image_byte;
        in_if.table_index <= r.table_index;
        in_if.table_red   <= r.table_red;
        in_if.table_green <= r.table_green;
        in_if.table_blue  <= r.table_blue;
        in_if.table_alpha <= r.table_alpha;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        pred.take_request(r);
    endtask

    task automatic send_image_byte(logic [7:0] b);
        t_pixel_req r;
        r             = t_pixel_req'(REQ_W'({$urandom, $urandom}));
        r.kind        = pngu_pkg::KIND_IMAGE;
        r.image_byte  = b;
        image_bytes_sent++;
        send_request(r);
    endtask

    task automatic send_table_write(logic [1:0] kind, logic [7:0] idx);
        t_pixel_req r;
        r             = t_pixel_req'(REQ_W'({$urandom, $urandom}));
        r.kind        = kind;
        r.table_index = idx;
        send_request(r);
    endtask

    function automatic logic [7:0] directed_filter(int unsigned row);
        case (row % 7)
            0:       return pngu_pkg::FILT_NONE;
            1:       return pngu_pkg::FILT_SUB;
            2:       return pngu_pkg::FILT_UP;
            3:       return pngu_pkg::FILT_AVG;
            4:       return pngu_pkg::FILT_PAETH;
            5:       return FILT_BAD_LO;
            default: return FILT_BAD_HI;
        endcase
    endfunction

    // one whole image at the current settings; table writes mixed in at noise_pct
    task automatic send_image(bit directed, int noise_pct);
        int unsigned rows, nbytes;
        logic [7:0]  f, d;
        logic [1:0]  nk;
        rows   = pred.row_total();
        nbytes = pred.row_width() * pred.pixel_bytes();
        for (int unsigned row = 0; row < rows; row++) begin
            if (directed) f = directed_filter(row);
            else if ($urandom_range(9) == 0) f = 8'($urandom_range(FILT_BAD_LO, FILT_BAD_HI));
            else f = 8'($urandom_range(pngu_pkg::FILT_PAETH));
            send_image_byte(f);
            for (int unsigned i = 0; i < nbytes; i++) begin
                if ($urandom_range(99) < noise_pct) begin
                    case ($urandom_range(2))
                        0:       nk = pngu_pkg::KIND_PALETTE;
                        1:       nk = pngu_pkg::KIND_ALPHA;
                        default: nk = KIND_IGNORED;
                    endcase
                    send_table_write(nk, 8'($urandom));
                end
                case ($urandom_range(9))
                    0:       d = 8'h00;
                    1:       d = 8'hFF;
                    default: d = 8'($urandom);
                endcase
                send_image_byte(d);
            end
        end
    endtask

    task automatic wait_drained();
        in_if.valid <= 1'b0;
        while (pred.expected_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [10:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        pred.write_reg(idx, data);
    endtask

    task automatic apply_settings(logic [10:0] w, logic [10:0] h, logic [2:0] fmt,
                                  logic trns_en);
        wait_drained();
        write_cfg(pngu_pkg::REG_WIDTH, w);
        write_cfg(pngu_pkg::REG_HEIGHT, h);
        write_cfg(pngu_pkg::REG_FORMAT, {8'd0, fmt});
        write_cfg(pngu_pkg::REG_TRNS, {10'd0, trns_en});
        cfg_if.valid <= 1'b0;
    endtask

    initial begin
        int unsigned start_bytes;
        logic [10:0] w;
        pred = new();
        i_rst_n           <= 1'b0;
        in_if.valid       <= 1'b0;
        in_if.kind        <= pngu_pkg::KIND_IMAGE;
        in_if.image_byte  <= '0;
        in_if.table_index <= '0;
        in_if.table_red   <= '0;
        in_if.table_green <= '0;
        in_if.table_blue  <= '0;
        in_if.table_alpha <= '0;
        cfg_if.valid      <= 1'b0;
        cfg_if.index      <= pngu_pkg::REG_WIDTH;
        cfg_if.data       <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: one rgb pixel
        send_image(1'b1, 0);

        // full palette so no unwritten entry is ever looked up
        for (int i = 0; i < pngu_pkg::PALETTE_ENTRIES; i++) begin
            send_table_write(pngu_pkg::KIND_PALETTE, 8'(i));
        end
        send_table_write(pngu_pkg::KIND_ALPHA, 8'h00);
        send_table_write(pngu_pkg::KIND_ALPHA, 8'hFF);
        repeat (16) send_table_write(pngu_pkg::KIND_ALPHA, 8'($urandom));

        // output held off so the pipeline backs up
        apply_settings(11'd2, 11'd7, pngu_pkg::FMT_RGB, 1'b0);
        hold_output = 1'b1;
        send_image(1'b1, 0);
        apply_settings(11'd3, 11'd5, pngu_pkg::FMT_GRAY, 1'b1);
        send_image(1'b1, 5);
        apply_settings(11'd2, 11'd7, pngu_pkg::FMT_PALETTE, 1'b1);
        send_image(1'b1, 5);
        apply_settings(11'd2, 11'd3, pngu_pkg::FMT_PALETTE, 1'b0);
        send_image(1'b1, 0);
        apply_settings(11'd3, 11'd7, pngu_pkg::FMT_GRAYA, 1'b0);
        send_image(1'b1, 0);

        // no idling on either side
        apply_settings(11'd2, 11'd7, pngu_pkg::FMT_RGBA, 1'b1);
        idle_pct = 0;
        send_image(1'b1, 0);
        idle_pct = 35;

        apply_settings(11'd1, 11'd2, FMT_ALT_LO, 1'b0);
        send_image(1'b1, 0);
        apply_settings(11'd1, 11'd1, FMT_ALT_HI, 1'b1);
        send_image(1'b1, 0);
        apply_settings(11'd0, 11'd0, pngu_pkg::FMT_GRAY, 1'b0);
        send_image(1'b1, 0);
        send_image(1'b1, 0);

        start_bytes = image_bytes_sent;
        while (image_bytes_sent - start_bytes < RANDOM_BYTES) begin
            w = ($urandom_range(19) == 0) ? 11'($urandom_range(9, 48))
                                          : 11'($urandom_range(8));
            apply_settings(w, 11'($urandom_range(4)), 3'($urandom_range(7)),
                           1'($urandom_range(1)));
            repeat ($urandom_range(1, 2)) send_image(1'b0, 10);
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (pred.errors == 0 && pred.expected_pixels.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

    initial begin
        #6_000_000;
        $display("tb failed");
        $finish;
    end

endmodule

### filelist.f
rtl/core/pngu_pkg.sv
rtl/core/pngu_if.sv
rtl/core/pngu_ram.sv
rtl/core/pngu_unfilter.sv
rtl/core/pngu_palette.sv
rtl/core/png_scanline_unfilter_top.sv
dv/tb.sv
